// ===== hdl/tlcd_pkg.sv =====
package tlcd_pkg;

  // default line length in character cells
  localparam int LINE_LEN_DEF = 16;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // register map, index taken from paddr[3:2]
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OPCODE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOP_ADDR = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOT_ADDR = 2'd3;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_TOP_ADR  = 7'b0000010,
    ST_TOP_DAT  = 7'b0000100,
    ST_BOT_ADR  = 7'b0001000,
    ST_BOT_DAT  = 7'b0010000,
    ST_SPIN_ADR = 7'b0100000,
    ST_SPIN_DAT = 7'b1000000
  } seq_state_t;

  // spinner glyphs in display order
  function automatic logic [7:0] spin_glyph(input logic [1:0] idx);
    logic [7:0] g;
    unique case (idx)
      2'd0: g = 8'h7C;
      2'd1: g = 8'h2F;
      2'd2: g = 8'h2D;
      2'd3: g = 8'hCD;
      default: g = 8'h7C;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/two_line_char_display_console_unit.sv =====
// Console front end for a two-line character display. Character items are
// stored in the current line buffer (carriage return ignored, characters past
// the end of the line dropped); a line feed produces 2*LINE_LEN+1 display
// writes (set-address, the previous line's first LINE_LEN-1 cells, set-address,
// the current line's LINE_LEN cells) and then starts a fresh blank line; a
// heartbeat item produces a set-address write and one spinner glyph for the
// top row's last cell. The flag last marks an item's final write. A stored
// character leaves the sequencer idle; a line feed or a heartbeat occupies
// the sequencer, with one display write per cycle through the line memory's
// single read port while the output is taken every cycle. Input ready is low
// while a sequence runs. The line memory is usable right after reset, no
// clearing pass is needed. Registers: 0x0 display_enable, 0x4
// set_address_opcode, 0x8 top_row_address, 0xC bottom_row_address; write
// them only while idle.
module two_line_char_display_console_unit
  import tlcd_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF,
  localparam int IDX_W = $clog2(LINE_LEN)
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  char_code,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_data,
  output logic [7:0]  write_byte,
  output logic        last
);

  logic                 display_enable;
  logic [7:0]           set_address_opcode;
  logic [6:0]           top_row_address;
  logic [6:0]           bottom_row_address;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  logic             wr_en;
  logic             wr_line;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_data;
  logic             clr_en;
  logic             clr_line;
  logic             rd_line_next;
  logic [IDX_W-1:0] rd_idx_next;
  logic [7:0]       rd_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable     <= 1'b1;
      set_address_opcode <= 8'd128;
      top_row_address    <= 7'd0;
      bottom_row_address <= 7'd64;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ENABLE:   display_enable     <= pwdata[0];
        REG_OPCODE:   set_address_opcode <= pwdata[7:0];
        REG_TOP_ADDR: top_row_address    <= pwdata[6:0];
        REG_BOT_ADDR: bottom_row_address <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:   prdata = {31'd0, display_enable};
      REG_OPCODE:   prdata = {24'd0, set_address_opcode};
      REG_TOP_ADDR: prdata = {25'd0, top_row_address};
      REG_BOT_ADDR: prdata = {25'd0, bottom_row_address};
      default:      prdata = 32'd0;
    endcase
  end

  tlcd_seq #(
    .LINE_LEN(LINE_LEN)
  ) u_seq (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .char_code         (char_code),
    .display_enable    (display_enable),
    .set_address_opcode(set_address_opcode),
    .top_row_address   (top_row_address),
    .bottom_row_address(bottom_row_address),
    .wr_en             (wr_en),
    .wr_line           (wr_line),
    .wr_idx            (wr_idx),
    .wr_data           (wr_data),
    .clr_en            (clr_en),
    .clr_line          (clr_line),
    .rd_line_next      (rd_line_next),
    .rd_idx_next       (rd_idx_next),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .is_data           (is_data),
    .write_byte        (write_byte),
    .last              (last)
  );

  tlcd_line_mem #(
    .LINE_LEN(LINE_LEN)
  ) u_line_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_line (wr_line),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .clr_en  (clr_en),
    .clr_line(clr_line),
    .rd_line (rd_line_next),
    .rd_idx  (rd_idx_next),
    .rd_data (rd_data)
  );

endmodule

// ===== hdl/tlcd_line_mem.sv =====
module tlcd_line_mem
  import tlcd_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF,
  localparam int IDX_W = $clog2(LINE_LEN)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             wr_line,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [7:0]       wr_data,
  input  logic             clr_en,
  input  logic             clr_line,
  input  logic             rd_line,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_data
);

  logic [7:0]          mem [2][LINE_LEN];
  logic [LINE_LEN-1:0] vld [2];
  logic [7:0]          rd_raw;
  logic                rd_vld;

  // cell storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_line][wr_idx] <= wr_data;
    end
    rd_raw <= mem[rd_line][rd_idx];
    rd_vld <= vld[rd_line][rd_idx];
  end

  // per-cell written flags, a cleared cell reads as space
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= '0;
      vld[1] <= '0;
    end else begin
      if (clr_en) begin
        vld[clr_line] <= '0;
      end
      if (wr_en) begin
        vld[wr_line][wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : CH_SPACE;

endmodule

// ===== hdl/tlcd_seq.sv =====
module tlcd_seq
  import tlcd_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF,
  localparam int IDX_W = $clog2(LINE_LEN),
  localparam int CUR_W = $clog2(LINE_LEN + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  input  logic [7:0]       char_code,
  // configuration
  input  logic             display_enable,
  input  logic [7:0]       set_address_opcode,
  input  logic [6:0]       top_row_address,
  input  logic [6:0]       bottom_row_address,
  // line memory
  output logic             wr_en,
  output logic             wr_line,
  output logic [IDX_W-1:0] wr_idx,
  output logic [7:0]       wr_data,
  output logic             clr_en,
  output logic             clr_line,
  output logic             rd_line_next,
  output logic [IDX_W-1:0] rd_idx_next,
  input  logic [7:0]       rd_data,
  // output channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             is_data,
  output logic [7:0]       write_byte,
  output logic             last
);

  localparam logic [IDX_W-1:0] TOP_END  = IDX_W'(LINE_LEN - 2);
  localparam logic [IDX_W-1:0] BOT_END  = IDX_W'(LINE_LEN - 1);
  localparam logic [7:0]       OFF_LAST = 8'(LINE_LEN - 1);
  localparam logic [CUR_W-1:0] ROOM_TOP = CUR_W'(LINE_LEN - 1);
  localparam logic [CUR_W-1:0] ROOM_BOT = CUR_W'(LINE_LEN);

  seq_state_t       state, state_next;
  logic             cur_line, cur_line_next;
  logic [CUR_W-1:0] cursor, cursor_next;
  logic [1:0]       spin, spin_next;
  logic             rd_line;
  logic [IDX_W-1:0] rd_idx;

  logic             accept;
  logic             out_free;
  logic             emit;
  logic [6:0]       addr_base;
  logic [7:0]       addr_off;
  logic [7:0]       addr_sum;
  logic             emit_is_data;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [CUR_W-1:0] room;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;
  assign emit     = out_free & (state != ST_IDLE);
  assign room     = cur_line ? ROOM_BOT : ROOM_TOP;

  // shared set-address adder
  always_comb begin
    addr_base = top_row_address;
    addr_off  = 8'd0;
    if (state == ST_BOT_ADR) begin
      addr_base = bottom_row_address;
    end
    if (state == ST_SPIN_ADR) begin
      addr_off = OFF_LAST;
    end
    addr_sum = set_address_opcode + {1'b0, addr_base} + addr_off;
  end

  // sequencer
  always_comb begin
    state_next    = state;
    cur_line_next = cur_line;
    cursor_next   = cursor;
    spin_next     = spin;
    rd_line_next  = rd_line;
    rd_idx_next   = rd_idx;
    wr_en         = 1'b0;
    wr_line       = cur_line;
    wr_idx        = cursor[IDX_W-1:0];
    wr_data       = char_code;
    clr_en        = 1'b0;
    clr_line      = ~cur_line;
    emit_is_data  = 1'b0;
    emit_byte     = addr_sum;
    emit_last     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && display_enable) begin
          if (command) begin
            state_next = ST_SPIN_ADR;
          end else if (char_code == CH_LF) begin
            state_next   = ST_TOP_ADR;
            rd_line_next = ~cur_line;
            rd_idx_next  = '0;
          end else if (char_code != CH_CR && cursor < room) begin
            wr_en       = 1'b1;
            cursor_next = cursor + 1'b1;
          end
        end
      end
      ST_TOP_ADR: begin
        if (emit) begin
          state_next = ST_TOP_DAT;
        end
      end
      ST_TOP_DAT: begin
        emit_is_data = 1'b1;
        emit_byte    = rd_data;
        if (emit) begin
          if (rd_idx == TOP_END) begin
            state_next   = ST_BOT_ADR;
            rd_line_next = cur_line;
            rd_idx_next  = '0;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
          end
        end
      end
      ST_BOT_ADR: begin
        if (emit) begin
          state_next = ST_BOT_DAT;
        end
      end
      ST_BOT_DAT: begin
        emit_is_data = 1'b1;
        emit_byte    = rd_data;
        if (rd_idx == BOT_END) begin
          emit_last = 1'b1;
          if (emit) begin
            state_next    = ST_IDLE;
            cur_line_next = ~cur_line;
            cursor_next   = '0;
            clr_en        = 1'b1;
          end
        end else if (emit) begin
          rd_idx_next = rd_idx + 1'b1;
        end
      end
      ST_SPIN_ADR: begin
        if (emit) begin
          state_next = ST_SPIN_DAT;
        end
      end
      ST_SPIN_DAT: begin
        emit_is_data = 1'b1;
        emit_byte    = spin_glyph(spin);
        emit_last    = 1'b1;
        if (emit) begin
          state_next = ST_IDLE;
          spin_next  = spin + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_line  <= 1'b0;
      cursor    <= '0;
      spin      <= '0;
      rd_line   <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cur_line <= cur_line_next;
      cursor   <= cursor_next;
      spin     <= spin_next;
      rd_line  <= rd_line_next;
      rd_idx   <= rd_idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (emit) begin
      is_data    <= emit_is_data;
      write_byte <= emit_byte;
      last       <= emit_last;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tlcd_pkg::*;

  localparam int LLEN = LINE_LEN_DEF;
  localparam int SETTLE_CYCLES = 2 * LLEN + 8;
  localparam int RANDOM_ITEMS = 120;

  // item commands and write kinds
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_BEAT = 1'b1;
  localparam logic WR_INSTR = 1'b0;
  localparam logic WR_DATA  = 1'b1;

  // row expectation comes from the predictor
  localparam int USE_MODEL = -1;

  typedef struct packed {
    logic       is_data;
    logic [7:0] wbyte;
    logic       last;
  } disp_write_t;

  typedef struct {
    bit                   is_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          val;
    logic                 cmd;
    logic [7:0]           code;
    int                   typed_n;
    logic [7:0]           typed_adr;
    logic [7:0]           typed_glyph;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  char_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        is_data;
  logic [7:0]  write_byte;
  logic        last;

  two_line_char_display_console_unit DUT (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // console model state
  logic [7:0] line_buf [2][LLEN];
  logic       cur_line;
  int         cursor;
  logic [1:0] spin_idx;
  logic       cfg_enable;
  logic [7:0] cfg_opcode;
  logic [6:0] cfg_top;
  logic [6:0] cfg_bot;

  disp_write_t expected_writes[$];
  disp_write_t new_writes[$];
  disp_write_t head_write;
  stim_row_t   directed_rows[$];
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          rx_hold = 0;

  function void reset_console_model();
    for (int l = 0; l < 2; l++)
      for (int i = 0; i < LLEN; i++) line_buf[l][i] = CH_SPACE;
    cur_line = 1'b0;
    cursor = 0;
    spin_idx = 2'd0;
    cfg_enable = 1'b1;
    cfg_opcode = 8'd128;
    cfg_top = 7'd0;
    cfg_bot = 7'd64;
  endfunction

  function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_ENABLE:   cfg_enable = val[0];
      REG_OPCODE:   cfg_opcode = val[7:0];
      REG_TOP_ADDR: cfg_top = val[6:0];
      REG_BOT_ADDR: cfg_bot = val[6:0];
      default: ;
    endcase
  endfunction

  function void emit_write(input logic kind, input logic [7:0] b);
    disp_write_t w;
    w.is_data = kind;
    w.wbyte = b;
    w.last = 1'b0;
    new_writes.push_back(w);
  endfunction

  // display writes caused by one item, left in new_writes
  function void predict_display_writes(input logic cmd, input logic [7:0] code);
    int         room;
    logic       prev;
    logic [7:0] adr;
    logic [7:0] glyph;
    new_writes.delete();
    if (!cfg_enable) return;
    if (cmd == CMD_BEAT) begin
      adr = cfg_opcode + cfg_top + 8'(LLEN - 1);
      case (spin_idx)
        2'd0: glyph = 8'h7C;
        2'd1: glyph = 8'h2F;
        2'd2: glyph = 8'h2D;
        default: glyph = 8'hCD;
      endcase
      emit_write(WR_INSTR, adr);
      emit_write(WR_DATA, glyph);
      spin_idx = spin_idx + 2'd1;
    end else if (code == CH_LF) begin
      prev = ~cur_line;
      adr = cfg_opcode + cfg_top;
      emit_write(WR_INSTR, adr);
      for (int i = 0; i < LLEN - 1; i++) emit_write(WR_DATA, line_buf[prev][i]);
      adr = cfg_opcode + cfg_bot;
      emit_write(WR_INSTR, adr);
      for (int i = 0; i < LLEN; i++) emit_write(WR_DATA, line_buf[cur_line][i]);
      // switch lines; line 0 keeps its spinner cell
      cur_line = prev;
      cursor = 0;
      room = cur_line ? LLEN : LLEN - 1;
      for (int i = 0; i < room; i++) line_buf[cur_line][i] = CH_SPACE;
    end else if (code != CH_CR) begin
      room = cur_line ? LLEN : LLEN - 1;
      if (cursor < room) begin
        line_buf[cur_line][cursor] = code;
        cursor++;
      end
    end
    if (new_writes.size() != 0) new_writes[new_writes.size() - 1].last = 1'b1;
  endfunction

  function int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void add_item(input logic cmd, input logic [7:0] code, input int n,
                         input logic [7:0] adr = 8'h00, input logic [7:0] glyph = 8'h00);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.val = '0;
    r.cmd = cmd;
    r.code = code;
    r.typed_n = n;
    r.typed_adr = adr;
    r.typed_glyph = glyph;
    directed_rows.push_back(r);
  endfunction

  function void add_cfg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.val = val;
    r.cmd = CMD_CHAR;
    r.code = '0;
    r.typed_n = 0;
    r.typed_adr = '0;
    r.typed_glyph = '0;
    directed_rows.push_back(r);
  endfunction

  // register write, setup then access phase; called at a falling edge
  task write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    paddr = {idx, 2'b00};
    pwdata = val;
    pwrite = 1'b1;
    psel = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    set_reg(idx, val);
  endtask

  // offer one item and hold it until accepted
  task push_item(input logic cmd, input logic [7:0] code);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : pick_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    char_code = code;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task send_checked(input logic cmd, input logic [7:0] code);
    if (cfg_enable && !(cmd == CMD_CHAR && code == CH_CR)) items_sent++;
    predict_display_writes(cmd, code);
    foreach (new_writes[i]) expected_writes.push_back(new_writes[i]);
    push_item(cmd, code);
  endtask

  task wait_drained();
    while (expected_writes.size() != 0) @(negedge clk);
  endtask

  // idle before register writes, allowing for a sequence still running
  task settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random bytes and beats, at times past the line end, then a line feed
  task send_line();
    int         n;
    int         r;
    logic [7:0] c;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 14);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_checked(CMD_CHAR, CH_CR);
      else if (r == 1) send_checked(CMD_BEAT, 8'($urandom));
      else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
        send_checked(CMD_CHAR, c);
      end
    end
    send_checked(CMD_CHAR, CH_LF);
    if ($urandom_range(0, 5) == 0) wait_drained();
  endtask

  function logic [31:0] pick_opcode();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd255;
      default: return 32'($urandom_range(0, 255));
    endcase
  endfunction

  function logic [31:0] pick_row_addr();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd127;
      default: return 32'($urandom_range(0, 127));
    endcase
  endfunction

  // receiver stalls, with calm stretches
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready = 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rx_hold = pick_gap();
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // compare each display write with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write is_data=%b write_byte=%h last=%b",
                 $realtime, is_data, write_byte, last);
        mismatch_cnt++;
      end else begin
        head_write = expected_writes.pop_front();
        if (is_data !== head_write.is_data) begin
          $display("%0t: is_data expected %b got %b", $realtime, head_write.is_data, is_data);
          mismatch_cnt++;
        end
        if (write_byte !== head_write.wbyte) begin
          $display("%0t: write_byte expected %h got %h", $realtime, head_write.wbyte,
                   write_byte);
          mismatch_cnt++;
        end
        if (last !== head_write.last) begin
          $display("%0t: last expected %b got %b", $realtime, head_write.last, last);
          mismatch_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    int        phase;
    int        r;
    reset_console_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    add_item(CMD_BEAT, 8'h00, 2, 8'h8F, 8'h7C);
    add_item(CMD_CHAR, CH_CR, 0);
    add_item(CMD_CHAR, 8'h00, 0);
    add_item(CMD_CHAR, 8'hFF, 0);
    for (int i = 0; i < LLEN - 3; i++) add_item(CMD_CHAR, 8'(8'h41 + i), 0);
    // top line already full, dropped
    add_item(CMD_CHAR, 8'h5A, 0);
    add_item(CMD_CHAR, CH_LF, USE_MODEL);
    add_item(CMD_BEAT, 8'hFF, 2, 8'h8F, 8'h2F);
    add_item(CMD_BEAT, 8'h55, 2, 8'h8F, 8'h2D);
    add_item(CMD_BEAT, 8'hAA, 2, 8'h8F, 8'hCD);
    // disabled: nothing happens
    add_cfg(REG_ENABLE, 32'd0);
    add_item(CMD_BEAT, 8'h00, 0);
    add_item(CMD_CHAR, CH_LF, 0);
    add_item(CMD_CHAR, 8'h33, 0);
    // address sums wrap at the extremes
    add_cfg(REG_ENABLE, 32'd1);
    add_cfg(REG_OPCODE, 32'd255);
    add_cfg(REG_TOP_ADDR, 32'd127);
    add_cfg(REG_BOT_ADDR, 32'd127);
    add_item(CMD_BEAT, 8'h00, 2, 8'h8D, 8'h7C);
    add_item(CMD_CHAR, CH_LF, USE_MODEL);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_idx, row.val);
      end else begin
        predict_display_writes(row.cmd, row.code);
        if (row.typed_n == USE_MODEL) begin
          foreach (new_writes[j]) expected_writes.push_back(new_writes[j]);
        end else if (row.typed_n == 2) begin
          expected_writes.push_back('{WR_INSTR, row.typed_adr, 1'b0});
          expected_writes.push_back('{WR_DATA, row.typed_glyph, 1'b1});
        end
        push_item(row.cmd, row.code);
      end
    end

    // random phases, each under its own register setting
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      write_reg(REG_ENABLE, (phase % 5 == 2) ? 32'd0 : 32'd1);
      write_reg(REG_OPCODE, (phase == 0) ? 32'd0 : pick_opcode());
      write_reg(REG_TOP_ADDR, (phase == 0) ? 32'd0 : pick_row_addr());
      write_reg(REG_BOT_ADDR, (phase == 0) ? 32'd0 : pick_row_addr());
      if (!cfg_enable) begin
        repeat (8) begin
          r = $urandom_range(0, 2);
          if (r == 0) send_checked(CMD_BEAT, 8'($urandom));
          else if (r == 1) send_checked(CMD_CHAR, CH_LF);
          else send_checked(CMD_CHAR, 8'($urandom));
        end
      end else begin
        repeat (3) begin
          r = $urandom_range(0, 9);
          if (r < 7) send_line();
          else if (r < 9) send_checked(CMD_BEAT, 8'($urandom));
          else send_checked(CMD_CHAR, 8'($urandom));
        end
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("two_line_char_display_console_unit test passed");
    end else begin
      $display("two_line_char_display_console_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("two_line_char_display_console_unit test failed");
    $finish;
  end

endmodule

// ===== two_line_char_display_console_unit.f =====
hdl/tlcd_pkg.sv
hdl/tlcd_line_mem.sv
hdl/tlcd_seq.sv
hdl/two_line_char_display_console_unit.sv
test/tb.sv
